FILE: src/lr_pkg.sv
// Shared constants and types for the line rasterizer.
// No dependencies; every other file of the block imports this package.
package lr_pkg;

	// Default coordinate width and fixed field widths
	localparam int COORD_BITS_DEF = 10;
	localparam int SIZE_BITS      = 11;
	localparam int COLOR_BITS     = 16;

	// Command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	// Screen size after reset
	localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 11'd320;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 11'd240;

	// Register index (word address bit)
	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// Input operation codes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

endpackage

FILE: src/lr_front.sv
// Front part of the line rasterizer: classifies a load transaction and
// derives the Bresenham setup (major axis, ordering, deltas). Uses lr_pkg.
module lr_front #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  steep,
	output logic [COORD_BITS-1:0] major_pos,
	output logic [COORD_BITS-1:0] major_end,
	output logic [COORD_BITS-1:0] minor_pos,
	output logic [COORD_BITS-1:0] major_delta,
	output logic [COORD_BITS-1:0] minor_delta,
	output logic                  minor_down
);
	import lr_pkg::*;

	logic [COORD_BITS-1:0] span_x;
	logic [COORD_BITS-1:0] span_y;
	logic [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min;
	logic [COORD_BITS-1:0] minor_end;
	logic                  swap;

	// Measure the extent of each axis
	assign span_x = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
	assign span_y = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);

	// Pick the major axis
	assign steep = span_y > span_x;
	assign a_maj = steep ? start_y : start_x;
	assign a_min = steep ? start_x : start_y;
	assign b_maj = steep ? end_y : end_x;
	assign b_min = steep ? end_x : end_y;

	// Order endpoints so the major coordinate rises
	assign swap      = a_maj > b_maj;
	assign major_pos = swap ? b_maj : a_maj;
	assign major_end = swap ? a_maj : b_maj;
	assign minor_pos = swap ? b_min : a_min;
	assign minor_end = swap ? a_min : b_min;

	// Deltas follow from the axis extents
	assign major_delta = steep ? span_y : span_x;
	assign minor_delta = steep ? span_x : span_y;
	assign minor_down  = minor_pos >= minor_end;

endmodule

FILE: src/lr_queue.sv
// Short command queue between the front and back parts of the rasterizer.
// Generic data width; uses lr_pkg for the default depth.
module lr_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = lr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output logic [DATA_W-1:0] pop_data
);
	import lr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [DATA_W-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == FULL_CNT;
	assign not_empty = count_q != '0;
	assign pop_data  = entries_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/lr_back.sv
// Back part of the line rasterizer: holds the active line, steps the
// Bresenham error term and drives the pixel output register. Uses lr_pkg.
module lr_back #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command from the queue
	input  logic                          cmd_valid,
	output logic                          cmd_pop,
	input  logic                          cmd_op,
	input  logic                          cmd_steep,
	input  logic [COORD_BITS-1:0]         cmd_major_pos,
	input  logic [COORD_BITS-1:0]         cmd_major_end,
	input  logic [COORD_BITS-1:0]         cmd_minor_pos,
	input  logic [COORD_BITS-1:0]         cmd_major_delta,
	input  logic [COORD_BITS-1:0]         cmd_minor_delta,
	input  logic                          cmd_minor_down,
	input  logic [lr_pkg::COLOR_BITS-1:0] cmd_color,
	// screen size
	input  logic [lr_pkg::SIZE_BITS-1:0]  screen_width,
	input  logic [lr_pkg::SIZE_BITS-1:0]  screen_height,
	// pixel output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COORD_BITS-1:0]         pixel_x,
	output logic [COORD_BITS-1:0]         pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                          on_screen,
	output logic                          last_pixel
);
	import lr_pkg::*;

	localparam int ERR_W = COORD_BITS + 2;
	localparam int CMP_W = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;

	// Line state
	logic                  active_q;
	logic                  steep_q;
	logic [COORD_BITS-1:0] major_pos_q;
	logic [COORD_BITS-1:0] major_end_q;
	logic [COORD_BITS-1:0] minor_pos_q;
	logic [COORD_BITS-1:0] major_delta_q;
	logic [COORD_BITS-1:0] minor_delta_q;
	logic [ERR_W-1:0]      err_q;
	logic                  minor_down_q;
	logic [COLOR_BITS-1:0] color_q;

	// Output register
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q;
	logic [COORD_BITS-1:0] pixel_y_q;
	logic [COLOR_BITS-1:0] pixel_color_q;
	logic                  on_screen_q;
	logic                  last_pixel_q;

	logic                  is_load;
	logic                  emit;
	logic                  out_free;
	logic                  last;
	logic [COORD_BITS-1:0] px;
	logic [COORD_BITS-1:0] py;
	logic                  in_bounds;
	logic [ERR_W-1:0]      err_dec;
	logic [ERR_W-1:0]      err_inc;

	// Decide whether the head command can retire this cycle
	assign is_load  = cmd_op == OP_LOAD;
	assign emit     = cmd_valid && !is_load && active_q;
	assign out_free = !out_valid_q || out_ready;
	assign cmd_pop  = cmd_valid && (!emit || out_free);

	// Form the current pixel
	assign last      = major_pos_q >= major_end_q;
	assign px        = steep_q ? minor_pos_q : major_pos_q;
	assign py        = steep_q ? major_pos_q : minor_pos_q;
	assign in_bounds = (CMP_W'(px) < CMP_W'(screen_width)) &&
	                   (CMP_W'(py) < CMP_W'(screen_height));

	// Error term update
	assign err_dec = err_q - ERR_W'(minor_delta_q);
	assign err_inc = err_dec + ERR_W'(major_delta_q);

	// Load or advance the line
	always_ff @(posedge clk) begin
		if (cmd_pop && is_load) begin
			steep_q       <= cmd_steep;
			major_pos_q   <= cmd_major_pos;
			major_end_q   <= cmd_major_end;
			minor_pos_q   <= cmd_minor_pos;
			major_delta_q <= cmd_major_delta;
			minor_delta_q <= cmd_minor_delta;
			minor_down_q  <= cmd_minor_down;
			color_q       <= cmd_color;
			err_q         <= ERR_W'(cmd_major_delta >> 1);
		end else if (cmd_pop && emit && !last) begin
			major_pos_q <= major_pos_q + 1'b1;
			if (err_dec[ERR_W-1]) begin
				err_q       <= err_inc;
				minor_pos_q <= minor_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
			end else begin
				err_q <= err_dec;
			end
		end
	end

	// Track the active line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cmd_pop && is_load) begin
			active_q <= 1'b1;
		end else if (cmd_pop && emit && last) begin
			active_q <= 1'b0;
		end
	end

	// Capture the pixel into the output register
	always_ff @(posedge clk) begin
		if (cmd_pop && emit) begin
			pixel_x_q     <= px;
			pixel_y_q     <= py;
			pixel_color_q <= color_q;
			on_screen_q   <= in_bounds;
			last_pixel_q  <= last;
		end
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (cmd_pop && emit) || (out_valid_q && !out_ready);
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign on_screen   = on_screen_q;
	assign last_pixel  = last_pixel_q;

endmodule

FILE: src/line_rasterizer.sv
// Top level of the Bresenham line rasterizer: configuration registers,
// front setup, command queue and back stepper. Uses lr_pkg and lr_* modules.
//
//   channel   | handshake             | contents
//   ----------+-----------------------+--------------------------------------
//   input     | in_valid / in_ready   | operation, start/end points, color
//   output    | out_valid / out_ready | pixel_x/y, pixel_color, flags
//   config    | APB psel/penable      | screen_width (0x0), screen_height (0x4)
//
// One transaction per cycle sustained while the queue has room: the front
// computes the setup of a load in the cycle it is accepted, and the back
// retires one queued command per cycle, a step's pixel being registered into
// the output register as it leaves the queue. The error-term update in the
// back is combinational. in_ready drops only when the four-entry queue is
// full; a pixel waiting in the output register holds a step at the queue head
// until it is taken. Reset clears the queue, the active line and the output
// valid; screen size returns to 320 x 240.
module line_rasterizer #(
	parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [COORD_BITS-1:0]            start_x,
	input  logic [COORD_BITS-1:0]            start_y,
	input  logic [COORD_BITS-1:0]            end_x,
	input  logic [COORD_BITS-1:0]            end_y,
	input  logic [lr_pkg::COLOR_BITS-1:0]    line_color,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [COORD_BITS-1:0]            pixel_x,
	output logic [COORD_BITS-1:0]            pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0]    pixel_color,
	output logic                             on_screen,
	output logic                             last_pixel,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lr_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [lr_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [lr_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                             pready
);
	import lr_pkg::*;

	localparam int ENTRY_W = 3 + 5 * COORD_BITS + COLOR_BITS;

	logic [SIZE_BITS-1:0]  width_q;
	logic [SIZE_BITS-1:0]  height_q;
	logic                  cfg_write;
	reg_idx_t              reg_sel;

	logic                  f_steep;
	logic [COORD_BITS-1:0] f_major_pos, f_major_end, f_minor_pos;
	logic [COORD_BITS-1:0] f_major_delta, f_minor_delta;
	logic                  f_minor_down;

	logic [ENTRY_W-1:0]    push_data;
	logic [ENTRY_W-1:0]    pop_data;
	logic                  q_full;
	logic                  q_not_empty;
	logic                  q_pop;

	// Configuration registers
	assign pready    = 1'b1;
	assign reg_sel   = reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[SIZE_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_BITS-1:0];
				default:    ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = APB_DATA_BITS'(width_q);
			REG_HEIGHT: prdata = APB_DATA_BITS'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Front: line setup
	lr_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.steep       (f_steep),
		.major_pos   (f_major_pos),
		.major_end   (f_major_end),
		.minor_pos   (f_minor_pos),
		.major_delta (f_major_delta),
		.minor_delta (f_minor_delta),
		.minor_down  (f_minor_down)
	);

	// Queue the classified command
	assign in_ready  = !q_full;
	assign push_data = {operation, f_steep, f_minor_down, f_major_pos, f_major_end,
	                    f_minor_pos, f_major_delta, f_minor_delta, line_color};

	lr_queue #(
		.DATA_W (ENTRY_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_data)
	);

	// Back: step the line and emit pixels
	lr_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (q_not_empty),
		.cmd_pop         (q_pop),
		.cmd_op          (pop_data[ENTRY_W-1]),
		.cmd_steep       (pop_data[ENTRY_W-2]),
		.cmd_minor_down  (pop_data[ENTRY_W-3]),
		.cmd_major_pos   (pop_data[COLOR_BITS+5*COORD_BITS-1 -: COORD_BITS]),
		.cmd_major_end   (pop_data[COLOR_BITS+4*COORD_BITS-1 -: COORD_BITS]),
		.cmd_minor_pos   (pop_data[COLOR_BITS+3*COORD_BITS-1 -: COORD_BITS]),
		.cmd_major_delta (pop_data[COLOR_BITS+2*COORD_BITS-1 -: COORD_BITS]),
		.cmd_minor_delta (pop_data[COLOR_BITS+COORD_BITS-1 -: COORD_BITS]),
		.cmd_color       (pop_data[COLOR_BITS-1:0]),
		.screen_width    (width_q),
		.screen_height   (height_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.pixel_color     (pixel_color),
		.on_screen       (on_screen),
		.last_pixel      (last_pixel)
	);

endmodule
